FILE: sv/rmsm_pkg.sv
`timescale 1ns / 1ps

package rmsm_pkg;

    localparam int MC     = 8;
    localparam int RES_W  = 8;
    localparam int PEP_W  = 16;
    localparam int SITE_W = 16;
    localparam int LEN_W  = 4;
    localparam int MODE_W = 3;
    localparam int ANCH_W = 3;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [MODE_W-1:0] RM_ANY    = 3'd0;
    localparam logic [MODE_W-1:0] RM_PROT_N = 3'd1;
    localparam logic [MODE_W-1:0] RM_PEP_N  = 3'd2;
    localparam logic [MODE_W-1:0] RM_PROT_C = 3'd3;
    localparam logic [MODE_W-1:0] RM_PEP_C  = 3'd4;

    localparam logic [1:0] REG_MOTIF = 2'd0;
    localparam logic [1:0] REG_LEN   = 2'd1;
    localparam logic [1:0] REG_MODE  = 2'd2;

    typedef logic [MC-1:0][7:0] t_motif;

    typedef struct packed {
        logic [RES_W-1:0] residue;
        logic [PEP_W-1:0] peptide_position;
        logic [PEP_W-1:0] peptide_length;
        logic             end_of_protein;
    } t_in_item;

    typedef struct packed {
        logic [SITE_W-1:0] site_position;
        logic              fits;
        logic              last_of_protein;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [ANCH_W-1:0] anchor;
        logic [MODE_W-1:0] mode;
        logic              eop;
    } t_eval_ctl;

    function automatic logic [7:0] f_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LA && c <= CH_LZ) begin
            r = c - CASE_OFS;
        end
        return r;
    endfunction

    function automatic logic f_char_match(input logic [7:0] m, input logic [7:0] s);
        logic r;
        r = (m == CH_X) || (m == s)
            || (m == CH_B && (s == CH_D || s == CH_N))
            || (m == CH_J && (s == CH_I || s == CH_L))
            || (m == CH_Z && (s == CH_E || s == CH_Q));
        return r;
    endfunction

endpackage

FILE: sv/residue_motif_site_matcher.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_in_data  (t_in_item)
// output    out        o_out_valid / i_out_stall o_out_data (t_out_item)
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One residue transfer is taken per cycle unless the input stalls.
// A residue carrying end of protein yields up to CAP verdicts (the smaller of MOTIF_MAX
// and eight), one per cycle from the output batch register while it is not stalled;
// the input stalls once the next residue that owes a verdict has to wait for them.
// Reset is synchronous and active low and clears the control state only.
// A stall at the output holds the batch, then the evaluation stage, then the input.

module residue_motif_site_matcher import rmsm_pkg::*; #(
    parameter int MOTIF_MAX = 8,
    parameter int POS_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int CAP    = (MOTIF_MAX < MC) ? MOTIF_MAX : MC;
    localparam int FILL_W = $clog2(MOTIF_MAX + 1);
    localparam int AGE_W  = (CAP > 1) ? $clog2(CAP) : 1;

    logic [DATA_W-1:0] r_motif;
    logic [LEN_W-1:0]  r_len;
    logic [MODE_W-1:0] r_mode;

    logic                 r_s1_valid;
    logic                 r_eop;
    logic [FILL_W-1:0]    r_fill;
    logic [POS_WIDTH-1:0] r_pos;
    logic [FILL_W-1:0]    n_fill;
    logic [POS_WIDTH-1:0] n_pos;

    logic                 r_b_valid;
    logic [CAP-1:0]       r_b_fits;
    logic [AGE_W-1:0]     r_b_age;
    logic [POS_WIDTH-1:0] r_b_pos;
    logic                 r_b_eop;

    t_motif    w_motif_up;
    t_eval_ctl w_ctl;
    logic [LEN_W-1:0]  w_len;
    logic [ANCH_W-1:0] w_anchor;
    logic [LEN_W-1:0]  w_d;
    logic              w_wr;
    logic              w_in_ok;
    logic              w_out_ok;
    logic              w_b_done;
    logic              w_s1_need;
    logic              w_s1_take;
    logic              w_load;
    logic [AGE_W-1:0]  w_start_age;
    logic [CAP-1:0]    w_fits;
    logic [POS_WIDTH-1:0] w_site;

    logic [MOTIF_MAX-1:0][RES_W-1:0] w_res;
    logic [MOTIF_MAX-1:0][PEP_W-1:0] w_pp;
    logic [MOTIF_MAX-1:0][PEP_W-1:0] w_pl;
    logic [MOTIF_MAX-1:0][MC-1:0]    w_match;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motif <= '0;
            r_len   <= LEN_W'(1);
            r_mode  <= RM_ANY;
        end else if (w_wr) begin
            unique case (paddr[4:3])
                REG_MOTIF: r_motif <= pwdata;
                REG_LEN:   r_len   <= pwdata[LEN_W-1:0];
                REG_MODE:  r_mode  <= pwdata[MODE_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_MOTIF: prdata = r_motif;
            REG_LEN:   prdata = DATA_W'(r_len);
            REG_MODE:  prdata = DATA_W'(r_mode);
            default:   prdata = '0;
        endcase
    end

    always_comb begin
        logic found;
        w_len = r_len;
        if (w_len == '0) begin
            w_len = LEN_W'(1);
        end
        if (w_len > LEN_W'(CAP)) begin
            w_len = LEN_W'(CAP);
        end
        for (int i = 0; i < MC; i++) begin
            w_motif_up[i] = f_upper(r_motif[8*i +: 8]);
        end
        found    = 1'b0;
        w_anchor = '0;
        for (int i = 0; i < CAP; i++) begin
            if (!found && LEN_W'(i) < w_len
                && r_motif[8*i +: 8] >= CH_UA && r_motif[8*i +: 8] <= CH_UZ) begin
                w_anchor = ANCH_W'(i);
                found    = 1'b1;
            end
        end
        w_d = w_len - LEN_W'(1) - LEN_W'(w_anchor);
    end

    assign w_ctl = '{len: w_len, anchor: w_anchor, mode: r_mode, eop: r_eop};

    genvar k;
    generate
        for (k = 0; k < MOTIF_MAX; k++) begin : g_cell
            if (k == 0) begin : g_head
                rmsm_cell u_cell (
                    .i_clk     (i_clk),
                    .i_shift   (w_in_ok),
                    .i_residue (i_in_data.residue),
                    .i_pp      (i_in_data.peptide_position),
                    .i_pl      (i_in_data.peptide_length),
                    .i_motif   (w_motif_up),
                    .o_residue (w_res[k]),
                    .o_pp      (w_pp[k]),
                    .o_pl      (w_pl[k]),
                    .o_match   (w_match[k])
                );
            end else begin : g_body
                rmsm_cell u_cell (
                    .i_clk     (i_clk),
                    .i_shift   (w_in_ok),
                    .i_residue (w_res[k-1]),
                    .i_pp      (w_pp[k-1]),
                    .i_pl      (w_pl[k-1]),
                    .i_motif   (w_motif_up),
                    .o_residue (w_res[k]),
                    .o_pp      (w_pp[k]),
                    .o_pl      (w_pl[k]),
                    .o_match   (w_match[k])
                );
            end
        end
    endgenerate

    rmsm_eval #(
        .MOTIF_MAX (MOTIF_MAX),
        .POS_WIDTH (POS_WIDTH),
        .CAP       (CAP),
        .FILL_W    (FILL_W)
    ) u_eval (
        .i_ctl   (w_ctl),
        .i_fill  (r_fill),
        .i_pos   (r_pos),
        .i_match (w_match),
        .i_pp    (w_pp),
        .i_pl    (w_pl),
        .o_fits  (w_fits)
    );

    assign w_out_ok  = r_b_valid && !i_out_stall;
    assign w_b_done  = w_out_ok && (!r_b_eop || r_b_age == '0);
    assign w_s1_need = r_eop || (32'(w_d) < 32'(r_fill));
    assign w_s1_take = !w_s1_need || !r_b_valid || w_b_done;
    assign w_load    = r_s1_valid && w_s1_take && w_s1_need;
    assign o_in_stall = r_s1_valid && !w_s1_take;
    assign w_in_ok    = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_eop && (32'(w_d) >= 32'(r_fill))) begin
            w_start_age = AGE_W'(r_fill - FILL_W'(1));
        end else begin
            w_start_age = AGE_W'(w_d);
        end
    end

    always_comb begin
        logic [FILL_W-1:0]    base_fill;
        logic [POS_WIDTH-1:0] base_pos;
        base_fill = r_eop ? '0 : r_fill;
        base_pos  = r_eop ? '0 : r_pos;
        n_fill = (base_fill == FILL_W'(MOTIF_MAX)) ? base_fill : base_fill + FILL_W'(1);
        n_pos  = (base_pos == '1) ? base_pos : base_pos + POS_WIDTH'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_eop      <= 1'b0;
            r_fill     <= '0;
            r_pos      <= '0;
        end else if (w_in_ok) begin
            r_s1_valid <= 1'b1;
            r_eop      <= i_in_data.end_of_protein;
            r_fill     <= n_fill;
            r_pos      <= n_pos;
        end else if (w_s1_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_load) begin
            r_b_valid <= 1'b1;
        end else if (w_b_done) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_b_fits <= w_fits;
            r_b_age  <= w_start_age;
            r_b_pos  <= r_pos;
            r_b_eop  <= r_eop;
        end else if (w_out_ok && !w_b_done) begin
            r_b_age  <= r_b_age - AGE_W'(1);
        end
    end

    assign w_site      = r_b_pos - POS_WIDTH'(r_b_age);
    assign o_out_valid = r_b_valid;
    assign o_out_data  = '{site_position:   SITE_W'(w_site),
                           fits:            r_b_fits[r_b_age],
                           last_of_protein: r_b_eop && (r_b_age == '0)};

    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_in_stall) |=> r_s1_valid)
        else $error("pending evaluation dropped while input stalled");

    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= MOTIF_MAX)
        else $error("fill count above window depth");

    a_new_protein: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_ok && r_eop) |=> (r_pos == POS_WIDTH'(1) && r_fill == FILL_W'(1)))
        else $error("new protein did not restart position and fill");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_s1_valid))
        else $error("pipeline not empty after reset");

endmodule

FILE: sv/rmsm_cell.sv
`timescale 1ns / 1ps

module rmsm_cell import rmsm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_shift,
    input  logic [RES_W-1:0] i_residue,
    input  logic [PEP_W-1:0] i_pp,
    input  logic [PEP_W-1:0] i_pl,
    input  t_motif           i_motif,
    output logic [RES_W-1:0] o_residue,
    output logic [PEP_W-1:0] o_pp,
    output logic [PEP_W-1:0] o_pl,
    output logic [MC-1:0]    o_match
);

    logic [RES_W-1:0] r_residue;
    logic [PEP_W-1:0] r_pp;
    logic [PEP_W-1:0] r_pl;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_residue <= i_residue;
            r_pp      <= i_pp;
            r_pl      <= i_pl;
        end
    end

    always_comb begin
        for (int i = 0; i < MC; i++) begin
            o_match[i] = f_char_match(i_motif[i], r_residue);
        end
    end

    assign o_residue = r_residue;
    assign o_pp      = r_pp;
    assign o_pl      = r_pl;

endmodule

FILE: sv/rmsm_eval.sv
`timescale 1ns / 1ps

module rmsm_eval import rmsm_pkg::*; #(
    parameter int MOTIF_MAX = 8,
    parameter int POS_WIDTH = 16,
    parameter int CAP       = (MOTIF_MAX < MC) ? MOTIF_MAX : MC,
    parameter int FILL_W    = $clog2(MOTIF_MAX + 1)
) (
    input  t_eval_ctl                        i_ctl,
    input  logic [FILL_W-1:0]                i_fill,
    input  logic [POS_WIDTH-1:0]             i_pos,
    input  logic [MOTIF_MAX-1:0][MC-1:0]     i_match,
    input  logic [MOTIF_MAX-1:0][PEP_W-1:0]  i_pp,
    input  logic [MOTIF_MAX-1:0][PEP_W-1:0]  i_pl,
    output logic [CAP-1:0]                   o_fits
);

    localparam int EXT_W = MOTIF_MAX + 2 * CAP;

    logic [CAP-1:0][EXT_W-1:0] w_ext;
    logic [CAP-1:0][EXT_W-1:0] w_sh;

    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            w_ext[i] = '0;
            for (int r = 0; r < MOTIF_MAX; r++) begin
                w_ext[i][r + CAP - 1] = i_match[r][i] && (FILL_W'(r) < i_fill);
            end
            w_sh[i] = w_ext[i] >> i_ctl.anchor;
        end
    end

    always_comb begin
        logic                 ok;
        logic                 term;
        logic                 last;
        logic [POS_WIDTH-1:0] site;
        for (int a = 0; a < CAP; a++) begin
            ok = 1'b1;
            for (int i = 0; i < CAP; i++) begin
                if (LEN_W'(i) < i_ctl.len && !w_sh[i][a + CAP - 1 - i]) begin
                    ok = 1'b0;
                end
            end
            site = i_pos - POS_WIDTH'(a);
            last = i_ctl.eop && (a == 0);
            unique case (i_ctl.mode)
                RM_PROT_N: term = (site <= POS_WIDTH'(2));
                RM_PEP_N:  term = (i_pp[a] <= PEP_W'(1));
                RM_PROT_C: term = last;
                RM_PEP_C:  term = (i_pp[a] >= i_pl[a]);
                default:   term = 1'b1;
            endcase
            o_fits[a] = ok && term;
        end
    end

endmodule

FILE: tb/tb_residue_motif_site_matcher.sv
`timescale 1ns / 1ps

module tb_residue_motif_site_matcher;
    import rmsm_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_MAX    = 10;
    localparam int POS_SAT       = 65535;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Shadow copy of the registers and of the residue history.
    logic [63:0]       motif_reg;
    logic [3:0]        motif_len_reg;
    logic [2:0]        mode_reg;
    logic [7:0]        res_hist     [MC];
    logic [15:0]       pep_idx_hist [MC];
    logic [15:0]       pep_len_hist [MC];
    int unsigned       residues_seen;
    int unsigned       hist_fill;

    t_out_item         verdicts_due [$];
    t_out_item         front_verdict;
    int                mismatches     = 0;
    int                cycle_count    = 0;
    int                src_idle_pct   = 0;
    int                sink_stall_pct = 0;

    residue_motif_site_matcher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    function automatic void clear_stream();
        int i;
        for (i = 0; i < MC; i++) begin
            res_hist[i]     = '0;
            pep_idx_hist[i] = '0;
            pep_len_hist[i] = '0;
        end
        residues_seen = 0;
        hist_fill     = 0;
    endfunction

    function automatic int motif_span();
        int l;
        l = motif_len_reg;
        if (l == 0) l = 1;
        if (l > MC) l = MC;
        return l;
    endfunction

    function automatic logic [7:0] motif_byte(input int i);
        return motif_reg[8*i +: 8];
    endfunction

    function automatic bit residue_fits_char(input logic [7:0] m, input logic [7:0] r);
        logic [7:0] mu;
        mu = (m >= CH_LA && m <= CH_LZ) ? m - CASE_OFS : m;
        if (mu == CH_X || mu == r) return 1'b1;
        case (mu)
            CH_B:    return r == CH_D || r == CH_N;
            CH_J:    return r == CH_I || r == CH_L;
            CH_Z:    return r == CH_E || r == CH_Q;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit site_verdict(input int age, input int span, input int anchor,
                                        input bit last);
        int i;
        int ra;
        for (i = 0; i < span; i++) begin
            ra = age + anchor - i;
            if (ra < 0 || ra >= int'(hist_fill)) return 1'b0;
            if (!residue_fits_char(motif_byte(i), res_hist[ra])) return 1'b0;
        end
        case (mode_reg)
            RM_PROT_N: return int'(residues_seen) - age <= 2;
            RM_PEP_N:  return pep_idx_hist[age] <= 16'd1;
            RM_PROT_C: return last;
            RM_PEP_C:  return pep_idx_hist[age] >= pep_len_hist[age];
            default:   return 1'b1;
        endcase
    endfunction

    function automatic void predict_site_verdicts(input t_in_item item);
        int        i;
        int        span;
        int        anchor;
        int        lag;
        int        age;
        bit        anchored;
        bit        last;
        t_out_item v;
        for (i = MC - 1; i > 0; i--) begin
            res_hist[i]     = res_hist[i-1];
            pep_idx_hist[i] = pep_idx_hist[i-1];
            pep_len_hist[i] = pep_len_hist[i-1];
        end
        res_hist[0]     = item.residue;
        pep_idx_hist[0] = item.peptide_position;
        pep_len_hist[0] = item.peptide_length;
        if (residues_seen < POS_SAT) residues_seen++;
        if (hist_fill < MC) hist_fill++;

        span     = motif_span();
        anchor   = 0;
        anchored = 1'b0;
        for (i = 0; i < span; i++) begin
            if (!anchored && motif_byte(i) >= CH_UA && motif_byte(i) <= CH_UZ) begin
                anchor   = i;
                anchored = 1'b1;
            end
        end
        lag = span - 1 - anchor;

        // The end of a protein flushes every verdict still owed, oldest first.
        for (i = 0; i <= (item.end_of_protein ? lag : 0); i++) begin
            age  = lag - i;
            last = item.end_of_protein && age == 0;
            if (age < int'(hist_fill)) begin
                v.site_position   = 16'(int'(residues_seen) - age);
                v.fits            = site_verdict(age, span, anchor, last);
                v.last_of_protein = last;
                verdicts_due.push_back(v);
            end
        end
        if (item.end_of_protein) clear_stream();
    endfunction

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("Mismatch in %0s at cycle %0d: expected %0h, got %0h",
                         field, cycle_count, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Unexpected verdict transfer at cycle %0d: site %0d",
                             cycle_count, o_out_data.site_position);
            end else begin
                front_verdict = verdicts_due.pop_front();
                check_field("site_position", front_verdict.site_position,
                            o_out_data.site_position);
                check_field("fits", 16'(front_verdict.fits), 16'(o_out_data.fits));
                check_field("last_of_protein", 16'(front_verdict.last_of_protein),
                            16'(o_out_data.last_of_protein));
            end
        end
    end

    // Each of these tasks starts and ends just after a falling edge.
    task automatic send_residue(input t_in_item item);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_site_verdicts(item);
        @(negedge i_clk);
    endtask

    task automatic send_peptide(input string s, input bit closes_protein);
        t_in_item item;
        int       i;
        for (i = 0; i < s.len(); i++) begin
            item.residue          = s[i];
            item.peptide_position = 16'(i + 1);
            item.peptide_length   = 16'(s.len());
            item.end_of_protein   = closes_protein && i == s.len() - 1;
            send_residue(item);
        end
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (verdicts_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [63:0] motif, input logic [3:0] len,
                             input logic [2:0] mode);
        write_reg(REG_MOTIF, motif);
        write_reg(REG_LEN, 64'(len));
        write_reg(REG_MODE, 64'(mode));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        motif_reg     = motif;
        motif_len_reg = len;
        mode_reg      = mode;
    endtask

    function automatic logic [63:0] pack_motif(input string s);
        logic [63:0] m;
        int          i;
        m = '0;
        for (i = 0; i < s.len() && i < MC; i++) m[8*i +: 8] = s[i];
        return m;
    endfunction

    function automatic logic [7:0] random_residue();
        string pool;
        pool = "DNILEQKSAXBJZ";
        if ($urandom_range(19) == 0) return 8'($urandom_range(255));
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    function automatic logic [63:0] random_motif();
        string       pool;
        logic [63:0] m;
        int          i;
        pool = "XxBbJjZzKkSsDNILEQ";
        for (i = 0; i < MC; i++)
            m[8*i +: 8] = ($urandom_range(11) == 0) ? 8'($urandom_range(255))
                                                   : pool[$urandom_range(pool.len() - 1)];
        return m;
    endfunction

    task automatic test_field_extremes();
        t_in_item item;
        wait_drain();
        configure(pack_motif("X"), 4'd1, RM_PEP_C);
        item = '{residue: 8'h00, peptide_position: 16'hFFFF, peptide_length: 16'h0001,
                 end_of_protein: 1'b0};
        send_residue(item);
        item = '{residue: 8'hFF, peptide_position: 16'h0001, peptide_length: 16'hFFFF,
                 end_of_protein: 1'b0};
        send_residue(item);
        item = '{residue: 8'h80, peptide_position: 16'hFFFF, peptide_length: 16'hFFFF,
                 end_of_protein: 1'b1};
        send_residue(item);
    endtask

    task automatic test_ambiguity_codes();
        wait_drain();
        configure(pack_motif("sBJZ"), 4'd4, RM_ANY);
        send_peptide("SDIE", 1'b1);
        // Without any capital letter the anchor falls on the first character.
        wait_drain();
        configure(pack_motif("bjzx"), 4'd4, RM_ANY);
        send_peptide("NLQA", 1'b1);
    endtask

    task automatic test_length_limits();
        wait_drain();
        configure(pack_motif("K"), 4'd0, RM_ANY);
        send_peptide("KA", 1'b1);
        wait_drain();
        configure(pack_motif("xxxKxxxx"), 4'd15, RM_ANY);
        send_peptide("AAKAA", 1'b1);
    endtask

    task automatic test_restriction_modes();
        logic [2:0] modes [6];
        int         i;
        modes = '{RM_PROT_N, RM_PEP_N, RM_PROT_C, RM_PEP_C, 3'd5, 3'd7};
        for (i = 0; i < 6; i++) begin
            wait_drain();
            configure(pack_motif("X"), 4'd1, modes[i]);
            send_peptide("AC", 1'b1);
        end
    endtask

    task automatic test_config_mid_protein();
        wait_drain();
        configure(pack_motif("Kx"), 4'd2, RM_ANY);
        send_peptide("KAK", 1'b0);
        wait_drain();
        configure(pack_motif("xK"), 4'd2, RM_PROT_C);
        send_peptide("KK", 1'b1);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int n_items);
        t_in_item item;
        int       sent;
        int       prot_len;
        int       pep_len;
        int       pep_pos;
        int       k;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        sent           = 0;
        while (sent < n_items) begin
            if (sent == 0 || $urandom_range(3) == 0) begin
                wait_drain();
                configure(random_motif(),
                          ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                   : 4'($urandom_range(1, 4)),
                          3'($urandom_range(7)));
            end
            prot_len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
            pep_pos  = 1;
            pep_len  = $urandom_range(1, 6);
            for (k = 0; k < prot_len; k++) begin
                item.residue = random_residue();
                if ($urandom_range(15) == 0) begin
                    item.peptide_position = 16'($urandom_range(65535));
                    item.peptide_length   = 16'($urandom_range(65535));
                end else begin
                    item.peptide_position = 16'(pep_pos);
                    item.peptide_length   = 16'(pep_len);
                end
                item.end_of_protein = k == prot_len - 1;
                send_residue(item);
                pep_pos++;
                if (pep_pos > pep_len) begin
                    pep_pos = 1;
                    pep_len = $urandom_range(1, 6);
                end
                sent++;
            end
        end
        wait_drain();
    endtask

    initial begin
        motif_reg     = '0;
        motif_len_reg = 4'd1;
        mode_reg      = RM_ANY;
        clear_stream();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_field_extremes();
        test_ambiguity_codes();
        test_length_limits();
        test_restriction_modes();
        test_config_mid_protein();
        test_random_traffic(0, 0, 105);
        test_random_traffic(77, 0, 105);
        test_random_traffic(0, 77, 105);
        test_random_traffic(24, 24, 105);
        wait_drain();

        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
